@@ design/pidc_pkg.sv @@
`timescale 1ns / 1ps

package pidc_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ERR_W     = DATA_W + 1;
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned STEP_W    = 16;
  localparam int unsigned Q_SHIFT   = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // Shared multiplier: a 33-bit magnitude times a 48-bit magnitude, in two 24-bit chunks.
  localparam int unsigned MUL_A_W   = ERR_W;
  localparam int unsigned MUL_B_W   = ACC_W;
  localparam int unsigned MUL_CHUNK = MUL_B_W / 2;
  localparam int unsigned PROD_W    = 64;

  // Divider: |diff| (34 bits) shifted up by Q_SHIFT.
  localparam int unsigned DIFF_W    = ERR_W + 1;
  localparam int unsigned DIV_N_W   = DIFF_W + Q_SHIFT;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_N_W);

  localparam logic signed [ACC_W-1:0] MAX48 = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] MIN48 = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP = 3'd5;

  localparam logic MODE_COMPUTE = 1'b0;
  localparam logic MODE_CLEAR   = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] measurement;
    logic        [DATA_W-1:0] delta_time;
  } pidc_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     at_limit;
  } pidc_out_t;

  typedef enum logic [1:0] {
    MSEL_INC,
    MSEL_P,
    MSEL_I,
    MSEL_D
  } pidc_mul_sel_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LO,
    PH_HI,
    PH_SUM
  } pidc_mul_phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INC,
    S_MP,
    S_MI,
    S_DWAIT,
    S_DSTART,
    S_MD,
    S_FIN
  } pidc_state_t;

  typedef struct packed {
    logic          latch_in;
    logic          mul_start;
    pidc_mul_sel_t mul_sel;
    logic          div_start;
    logic          take_inc;
    logic          take_div;
    logic          take_term;
    logic          term_init;
    logic          finish;
  } pidc_cmd_t;

  typedef struct packed {
    logic mode_clear;
    logic short_step;
    logic primed;
    logic mul_done;
    logic div_busy;
  } pidc_stat_t;

endpackage

@@ design/pidc_mul.sv @@
`timescale 1ns / 1ps

// Unsigned multiply of two magnitudes, result divided by 2^16 and truncated.
// The wide operand is taken in two chunks, one partial product per cycle.
module pidc_mul import pidc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a_mag,
  input  logic [MUL_B_W-1:0] b_mag,
  output logic               done,
  output logic [PROD_W-1:0]  m
);

  pidc_mul_phase_t                  phase_r, phase_nxt;
  logic                             done_r, done_nxt;
  logic [MUL_A_W-1:0]               a_r, a_nxt;
  logic [MUL_B_W-1:0]               b_r, b_nxt;
  logic [MUL_A_W+MUL_CHUNK-1:0]     prod_r, prod_nxt;
  logic [MUL_A_W+MUL_B_W-1:0]       acc_r, acc_nxt;

  always_comb begin
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    a_nxt     = a_r;
    b_nxt     = b_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (start) begin
          a_nxt     = a_mag;
          b_nxt     = b_mag;
          phase_nxt = PH_LO;
        end
      end
      PH_LO: begin
        prod_nxt  = a_r * b_r[MUL_CHUNK-1:0];
        phase_nxt = PH_HI;
      end
      PH_HI: begin
        acc_nxt   = {{(MUL_B_W-MUL_CHUNK){1'b0}}, prod_r};
        prod_nxt  = a_r * b_r[MUL_B_W-1:MUL_CHUNK];
        phase_nxt = PH_SUM;
      end
      PH_SUM: begin
        acc_nxt   = acc_r + {prod_r, {MUL_CHUNK{1'b0}}};
        done_nxt  = 1'b1;
        phase_nxt = PH_IDLE;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign done = done_r;
  assign m    = acc_r[PROD_W+Q_SHIFT-1:Q_SHIFT];

endmodule

@@ design/pidc_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module pidc_div import pidc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DATA_W-1:0]  divisor,
  output logic               busy,
  output logic [DIV_N_W-1:0] quot
);

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_N_W-1:0]   q_r, q_nxt;
  logic [DATA_W-1:0]    rem_r, rem_nxt;
  logic [DATA_W-1:0]    div_r, div_nxt;
  logic [DATA_W:0]      rem_sh;
  logic [DATA_W:0]      trial;
  logic                 fits;

  assign rem_sh = {rem_r, q_r[DIV_N_W-1]};
  assign trial  = rem_sh - {1'b0, div_r};
  assign fits   = rem_sh >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
      cnt_nxt  = DIV_CNT_W'(DIV_N_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so it fits in DATA_W bits.
      rem_nxt = fits ? trial[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      q_nxt   = {q_r[DIV_N_W-2:0], fits};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

@@ design/pidc_dp.sv @@
`timescale 1ns / 1ps

// Datapath: configuration registers, controller state, shared multiplier,
// divider, clamp and the output register.
module pidc_dp import pidc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  input  pidc_in_t             in_data,
  input  pidc_cmd_t            cmd,
  output pidc_stat_t           stat,
  output pidc_out_t            out_data
);

  function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
    mag32 = v[DATA_W-1] ? (DATA_W'(0) - v) : v;
  endfunction

  function automatic logic [ACC_W-1:0] mag48(input logic [ACC_W-1:0] v);
    mag48 = v[ACC_W-1] ? (ACC_W'(0) - v) : v;
  endfunction

  logic signed [DATA_W-1:0] gain_p_r, gain_p_nxt;
  logic signed [DATA_W-1:0] gain_i_r, gain_i_nxt;
  logic signed [DATA_W-1:0] gain_d_r, gain_d_nxt;
  logic signed [DATA_W-1:0] floor_r, floor_nxt;
  logic signed [DATA_W-1:0] ceil_r, ceil_nxt;
  logic [STEP_W-1:0]        min_step_r, min_step_nxt;

  logic signed [ACC_W-1:0]  integ_r, integ_nxt;
  logic signed [ERR_W-1:0]  last_err_r, last_err_nxt;
  logic                     primed_r, primed_nxt;

  logic                     mode_r, mode_nxt;
  logic                     short_r, short_nxt;
  logic signed [ERR_W-1:0]  err_r, err_nxt;
  logic [DATA_W-1:0]        dt_r, dt_nxt;
  logic signed [ACC_W-1:0]  integ_new_r, integ_new_nxt;
  logic signed [ACC_W-1:0]  deriv_r, deriv_nxt;
  logic signed [PROD_W-1:0] sum_r, sum_nxt;
  logic                     neg_r, neg_nxt;
  logic                     dneg_r, dneg_nxt;
  pidc_out_t                out_r, out_nxt;

  logic [MUL_A_W-1:0]       op_a;
  logic [MUL_B_W-1:0]       op_b;
  logic                     op_neg;
  logic                     mul_done;
  logic [PROD_W-1:0]        mul_m;
  logic signed [PROD_W-1:0] term;

  logic [ERR_W-1:0]         err_mag;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        diff_mag;
  logic                     div_busy;
  logic [DIV_N_W-1:0]       quot;

  logic signed [ACC_W+2:0]  inc_sum;
  logic signed [ACC_W-1:0]  inc_sat;
  logic signed [ACC_W-1:0]  deriv_sat;
  logic signed [PROD_W-1:0] floor_ext;
  logic signed [PROD_W-1:0] ceil_ext;
  logic signed [DATA_W-1:0] drive;
  logic                     limit;

  assign err_mag = err_r[ERR_W-1] ? (ERR_W'(0) - err_r) : err_r;

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd.mul_sel)
      MSEL_INC: begin
        op_a   = err_mag;
        op_b   = {{(MUL_B_W-DATA_W){1'b0}}, dt_r};
        op_neg = err_r[ERR_W-1];
      end
      MSEL_P: begin
        op_a   = {1'b0, mag32(gain_p_r)};
        op_b   = {{(MUL_B_W-ERR_W){1'b0}}, err_mag};
        op_neg = gain_p_r[DATA_W-1] ^ err_r[ERR_W-1];
      end
      MSEL_I: begin
        op_a   = {1'b0, mag32(gain_i_r)};
        op_b   = mag48(integ_new_r);
        op_neg = gain_i_r[DATA_W-1] ^ integ_new_r[ACC_W-1];
      end
      default: begin
        op_a   = {1'b0, mag32(gain_d_r)};
        op_b   = mag48(deriv_r);
        op_neg = gain_d_r[DATA_W-1] ^ deriv_r[ACC_W-1];
      end
    endcase
  end

  pidc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a_mag (op_a),
    .b_mag (op_b),
    .done  (mul_done),
    .m     (mul_m)
  );

  assign term = neg_r ? (PROD_W'(0) - mul_m) : mul_m;

  assign diff     = {err_r[ERR_W-1], err_r} - {last_err_r[ERR_W-1], last_err_r};
  assign diff_mag = diff[DIFF_W-1] ? (DIFF_W'(0) - diff) : diff;

  pidc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({diff_mag, {Q_SHIFT{1'b0}}}),
    .divisor  (dt_r),
    .busy     (div_busy),
    .quot     (quot)
  );

  // The increment magnitude is at most 2^48, so its low 50 bits hold it signed.
  assign inc_sum = {{3{integ_r[ACC_W-1]}}, integ_r} + {term[ACC_W+1], term[ACC_W+1:0]};

  always_comb begin
    if (inc_sum[ACC_W+2:ACC_W-1] == '0 || inc_sum[ACC_W+2:ACC_W-1] == '1) begin
      inc_sat = inc_sum[ACC_W-1:0];
    end else begin
      inc_sat = inc_sum[ACC_W+2] ? MIN48 : MAX48;
    end
  end

  always_comb begin
    if (|quot[DIV_N_W-1:ACC_W-1]) begin
      deriv_sat = dneg_r ? MIN48 : MAX48;
    end else begin
      deriv_sat = dneg_r ? (ACC_W'(0) - quot[ACC_W-1:0]) : quot[ACC_W-1:0];
    end
  end

  assign floor_ext = {{(PROD_W-DATA_W){floor_r[DATA_W-1]}}, floor_r};
  assign ceil_ext  = {{(PROD_W-DATA_W){ceil_r[DATA_W-1]}}, ceil_r};

  // Floor is checked first, so with crossed limits a sum below the floor gives the floor and any other sum the ceiling.
  always_comb begin
    if (sum_r < floor_ext) begin
      drive = floor_r;
    end else if (sum_r < ceil_ext) begin
      drive = sum_r[DATA_W-1:0];
    end else begin
      drive = ceil_r;
    end
    limit = (drive == floor_r) || (drive == ceil_r);
  end

  always_comb begin
    gain_p_nxt    = gain_p_r;
    gain_i_nxt    = gain_i_r;
    gain_d_nxt    = gain_d_r;
    floor_nxt     = floor_r;
    ceil_nxt      = ceil_r;
    min_step_nxt  = min_step_r;
    integ_nxt     = integ_r;
    last_err_nxt  = last_err_r;
    primed_nxt    = primed_r;
    mode_nxt      = mode_r;
    short_nxt     = short_r;
    err_nxt       = err_r;
    dt_nxt        = dt_r;
    integ_new_nxt = integ_new_r;
    deriv_nxt     = deriv_r;
    sum_nxt       = sum_r;
    neg_nxt       = neg_r;
    dneg_nxt      = dneg_r;
    out_nxt       = out_r;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_P:   gain_p_nxt   = cfg_wdata;
        REG_GAIN_I:   gain_i_nxt   = cfg_wdata;
        REG_GAIN_D:   gain_d_nxt   = cfg_wdata;
        REG_FLOOR:    floor_nxt    = cfg_wdata;
        REG_CEILING:  ceil_nxt     = cfg_wdata;
        REG_MIN_STEP: min_step_nxt = cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end

    if (cmd.latch_in) begin
      mode_nxt  = in_data.mode;
      short_nxt = in_data.delta_time <= {{(DATA_W-STEP_W){1'b0}}, min_step_r};
      err_nxt   = {in_data.setpoint[DATA_W-1], in_data.setpoint}
                - {in_data.measurement[DATA_W-1], in_data.measurement};
      dt_nxt    = in_data.delta_time;
    end

    if (cmd.mul_start) begin
      neg_nxt = op_neg;
    end
    if (cmd.div_start) begin
      dneg_nxt = diff[DIFF_W-1];
    end
    if (cmd.take_inc) begin
      integ_new_nxt = inc_sat;
    end
    if (cmd.take_div) begin
      deriv_nxt = primed_r ? deriv_sat : '0;
    end
    if (cmd.take_term) begin
      sum_nxt = cmd.term_init ? term : sum_r + term;
    end

    if (cmd.finish) begin
      if (mode_r == MODE_CLEAR) begin
        integ_nxt    = '0;
        last_err_nxt = '0;
        primed_nxt   = 1'b0;
        out_nxt      = '0;
      end else if (short_r) begin
        out_nxt = '0;
      end else begin
        out_nxt.drive    = drive;
        out_nxt.at_limit = limit;
        // At a limit the integral keeps its value from before this step.
        if (!limit) begin
          integ_nxt = integ_new_r;
        end
        last_err_nxt = err_r;
        primed_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r   <= 32'sd65536;
      gain_i_r   <= '0;
      gain_d_r   <= '0;
      floor_r    <= -32'sd65536;
      ceil_r     <= 32'sd65536;
      min_step_r <= 16'd6;
      integ_r    <= '0;
      last_err_r <= '0;
      primed_r   <= 1'b0;
    end else begin
      gain_p_r   <= gain_p_nxt;
      gain_i_r   <= gain_i_nxt;
      gain_d_r   <= gain_d_nxt;
      floor_r    <= floor_nxt;
      ceil_r     <= ceil_nxt;
      min_step_r <= min_step_nxt;
      integ_r    <= integ_nxt;
      last_err_r <= last_err_nxt;
      primed_r   <= primed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    short_r     <= short_nxt;
    err_r       <= err_nxt;
    dt_r        <= dt_nxt;
    integ_new_r <= integ_new_nxt;
    deriv_r     <= deriv_nxt;
    sum_r       <= sum_nxt;
    neg_r       <= neg_nxt;
    dneg_r      <= dneg_nxt;
    out_r       <= out_nxt;
  end

  assign stat.mode_clear = (mode_r == MODE_CLEAR);
  assign stat.short_step = short_r;
  assign stat.primed     = primed_r;
  assign stat.mul_done   = mul_done;
  assign stat.div_busy   = div_busy;

  assign out_data = out_r;

endmodule

@@ design/pidc_ctrl.sv @@
`timescale 1ns / 1ps

// Sequencer: walks one item through the datapath and owns both handshakes.
module pidc_ctrl import pidc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  pidc_stat_t stat,
  output pidc_cmd_t  cmd
);

  pidc_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.mul_sel   = MSEL_INC;
    in_ready      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.mode_clear || stat.short_step) begin
          state_nxt = S_FIN;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MSEL_INC;
          cmd.div_start = stat.primed;
          state_nxt     = S_INC;
        end
      end
      S_INC: begin
        if (stat.mul_done) begin
          cmd.take_inc  = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MSEL_P;
          state_nxt     = S_MP;
        end
      end
      S_MP: begin
        if (stat.mul_done) begin
          cmd.take_term = 1'b1;
          cmd.term_init = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MSEL_I;
          state_nxt     = S_MI;
        end
      end
      S_MI: begin
        if (stat.mul_done) begin
          cmd.take_term = 1'b1;
          state_nxt     = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (!stat.div_busy) begin
          cmd.take_div = 1'b1;
          state_nxt    = S_DSTART;
        end
      end
      S_DSTART: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MSEL_D;
        state_nxt     = S_MD;
      end
      S_MD: begin
        if (stat.mul_done) begin
          cmd.take_term = 1'b1;
          state_nxt     = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ design/pid_controller_antiwindup_core.sv @@
`timescale 1ns / 1ps

// PID controller with clamping anti-windup, signed Q16.16.
// Input channel (in_valid/in_ready/in_data): one item is either a control step
// (setpoint, measurement, delta_time) or a clear of the integral and history.
// Result channel (out_valid/out_ready/out_data): exactly one item per input
// item, in order, carrying the clamped drive and the at-limit flag.
// Configuration (cfg_we/cfg_index/cfg_wdata): gains, drive limits and the
// minimum time step, written while no item is in flight.
// A clear or a too-short step goes straight to the result; a control step runs
// the integral increment and the proportional, integral and derivative
// products in turn on one shared multiplier. Once the block is primed, a
// radix-2 divider forms the derivative alongside them, and the derivative
// product waits for it. A new item can be taken in the cycle after the
// previous result is loaded.
// A result waits in the output register while the receiver stalls; the next
// item is still accepted and worked on, and only the final load waits.
// Synchronous reset restores the default configuration, clears the integral,
// the previous error and the first-step flag, and empties the output.
module pid_controller_antiwindup_core import pidc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pidc_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pidc_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  pidc_cmd_t  cmd;
  pidc_stat_t stat;

  // Sequencer: decides which datapath step runs each cycle.
  pidc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: holds configuration, the controller state and the arithmetic.
  pidc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

@@ design/pidc_checker.sv @@
`timescale 1ns / 1ps

module pidc_checker import pidc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input pidc_out_t out_data
);

  // The output register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // One item at a time: the block is busy right after taking an item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");

  // A new result is loaded only as the block returns to waiting for input.
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result appeared while block still busy");

endmodule

bind pid_controller_antiwindup_core pidc_checker u_pidc_checker (.*);
